// ===== rtl/core/gvbs_pkg.sv =====
// Shared types and constants of the garbage-collection victim block selector.
package gvbs_pkg;

    // Default sizing of the block table.
    localparam int DEF_BLOCK_DEPTH = 1024;
    localparam int DEF_COUNT_BITS  = 16;

    // Fixed field widths of the item channels and the register port.
    localparam int IDX_W   = 10;
    localparam int VIDX_W  = 11;
    localparam int PAGE_W  = 16;
    localparam int STAMP_W = 48;
    localparam int LS_W    = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Item functions.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    // Selection modes.
    localparam logic MODE_GREEDY = 1'b0;
    localparam logic MODE_EDT    = 1'b1;

    // Block list states.
    localparam logic [LS_W-1:0] LS_EMPTY     = 3'd0;
    localparam logic [LS_W-1:0] LS_OPEN      = 3'd1;
    localparam logic [LS_W-1:0] LS_FULL      = 3'd2;
    localparam logic [LS_W-1:0] LS_GC_IN_USE = 3'd3;
    localparam logic [LS_W-1:0] LS_GC_READ   = 3'd4;
    localparam logic [LS_W-1:0] LS_GC_WRITE  = 3'd5;

    // Register indexes (word address on the register port).
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_CEILING = 2'd1;
    localparam logic [1:0] REG_BLOCKS  = 2'd2;

    // Register reset values.
    localparam logic [PAGE_W-1:0] CEILING_RST = 16'hFFFF;
    localparam logic [VIDX_W-1:0] BLOCKS_RST  = 11'd1024;

    typedef struct packed {
        logic              selection_mode;
        logic [PAGE_W-1:0] valid_ceiling;
        logic [VIDX_W-1:0] blocks_in_use;
    } cfg_t;

endpackage

// ===== rtl/core/gvbs_if.sv =====
// Request and response channel interfaces of the victim block selector.
interface gvbs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [gvbs_pkg::IDX_W-1:0]  block_index;
    logic [gvbs_pkg::LS_W-1:0]   list_state;
    logic [gvbs_pkg::PAGE_W-1:0] total_pages;
    logic [gvbs_pkg::PAGE_W-1:0] invalid_pages;
    logic [gvbs_pkg::STAMP_W-1:0] expiry_stamp;
    logic                        from_read_list;

    modport source (
        output valid, func, block_index, list_state, total_pages, invalid_pages,
               expiry_stamp, from_read_list,
        input  ready
    );
    modport sink (
        input  valid, func, block_index, list_state, total_pages, invalid_pages,
               expiry_stamp, from_read_list,
        output ready
    );
endinterface

interface gvbs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [gvbs_pkg::VIDX_W-1:0] victim_index;
    logic [gvbs_pkg::PAGE_W-1:0] victim_valid_pages;

    modport source (
        output valid, found, victim_index, victim_valid_pages,
        input  ready
    );
    modport sink (
        input  valid, found, victim_index, victim_valid_pages,
        output ready
    );
endinterface

// ===== rtl/core/gvbs_cfg.sv =====
// APB register file holding the selection mode, valid ceiling and scan length.
module gvbs_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gvbs_pkg::PADDR_W-1:0] paddr,
    input  logic [gvbs_pkg::PDATA_W-1:0] pwdata,
    output logic [gvbs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output gvbs_pkg::cfg_t               cfg
);
    import gvbs_pkg::*;

    logic       mode_reg;
    logic [PAGE_W-1:0] ceiling_reg;
    logic [VIDX_W-1:0] blocks_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_GREEDY;
            ceiling_reg <= CEILING_RST;
            blocks_reg  <= BLOCKS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MODE:    mode_reg    <= pwdata[0];
                REG_CEILING: ceiling_reg <= pwdata[PAGE_W-1:0];
                REG_BLOCKS:  blocks_reg  <= pwdata[VIDX_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MODE:    prdata = {{(PDATA_W-1){1'b0}}, mode_reg};
            REG_CEILING: prdata = {{(PDATA_W-PAGE_W){1'b0}}, ceiling_reg};
            REG_BLOCKS:  prdata = {{(PDATA_W-VIDX_W){1'b0}}, blocks_reg};
            default:     prdata = '0;
        endcase
    end

    assign cfg.selection_mode = mode_reg;
    assign cfg.valid_ceiling  = ceiling_reg;
    assign cfg.blocks_in_use  = blocks_reg;

endmodule

// ===== rtl/core/gvbs_rec_mem.sv =====
// Block record store: a list state memory and a page count and stamp memory.
module gvbs_rec_mem #(
    parameter int BLOCK_DEPTH = gvbs_pkg::DEF_BLOCK_DEPTH,
    parameter int COUNT_BITS  = gvbs_pkg::DEF_COUNT_BITS,
    localparam int ADDR_W     = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          st_we,
    input  logic [ADDR_W-1:0]             st_waddr,
    input  logic [gvbs_pkg::LS_W-1:0]     st_wdata,
    input  logic                          d_we,
    input  logic [ADDR_W-1:0]             d_waddr,
    input  logic [COUNT_BITS-1:0]         d_wtotal,
    input  logic [COUNT_BITS-1:0]         d_winvalid,
    input  logic [gvbs_pkg::STAMP_W-1:0]  d_wstamp,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [gvbs_pkg::LS_W-1:0]     rd_state,
    output logic [COUNT_BITS-1:0]         rd_total,
    output logic [COUNT_BITS-1:0]         rd_invalid,
    output logic [gvbs_pkg::STAMP_W-1:0]  rd_stamp
);
    import gvbs_pkg::*;

    localparam int DATA_W = 2 * COUNT_BITS + STAMP_W;

    logic [LS_W-1:0]   st_mem [BLOCK_DEPTH];
    logic [DATA_W-1:0] d_mem  [BLOCK_DEPTH];
    logic [DATA_W-1:0] d_rdata;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (rd_en)
        begin
            rd_state <= st_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            d_mem[d_waddr] <= {d_wtotal, d_winvalid, d_wstamp};
        end
        if (rd_en)
        begin
            d_rdata <= d_mem[rd_addr];
        end
    end

    assign rd_total   = d_rdata[DATA_W-1 -: COUNT_BITS];
    assign rd_invalid = d_rdata[STAMP_W +: COUNT_BITS];
    assign rd_stamp   = d_rdata[STAMP_W-1:0];

endmodule

// ===== rtl/core/gvbs_scan.sv =====
// Sequencer: clears the state memory, stores records and scans for a victim.
module gvbs_scan #(
    parameter int BLOCK_DEPTH = gvbs_pkg::DEF_BLOCK_DEPTH,
    parameter int COUNT_BITS  = gvbs_pkg::DEF_COUNT_BITS,
    localparam int ADDR_W     = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gvbs_pkg::cfg_t                cfg,
    gvbs_req_if.sink                      req,
    gvbs_rsp_if.source                    rsp,
    output logic                          st_we,
    output logic [ADDR_W-1:0]             st_waddr,
    output logic [gvbs_pkg::LS_W-1:0]     st_wdata,
    output logic                          d_we,
    output logic [ADDR_W-1:0]             d_waddr,
    output logic [COUNT_BITS-1:0]         d_wtotal,
    output logic [COUNT_BITS-1:0]         d_winvalid,
    output logic [gvbs_pkg::STAMP_W-1:0]  d_wstamp,
    output logic                          rd_en,
    output logic [ADDR_W-1:0]             rd_addr,
    input  logic [gvbs_pkg::LS_W-1:0]     rd_state,
    input  logic [COUNT_BITS-1:0]         rd_total,
    input  logic [COUNT_BITS-1:0]         rd_invalid,
    input  logic [gvbs_pkg::STAMP_W-1:0]  rd_stamp
);
    import gvbs_pkg::*;

    localparam int CNT_W = $clog2(BLOCK_DEPTH + 1);
    localparam int CMP_W = (COUNT_BITS > PAGE_W) ? COUNT_BITS : PAGE_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [ADDR_W-1:0]    clr_reg;
    logic [CNT_W-1:0]     iss_reg;
    logic [CNT_W-1:0]     limit_reg;
    logic                 pend_reg;
    logic [ADDR_W-1:0]    ev_idx_reg;
    logic                 side_reg;
    logic                 edt_reg;
    logic                 have_reg;
    logic [ADDR_W-1:0]    best_reg;
    logic [COUNT_BITS-1:0] best_valid_reg;
    logic [CMP_W-1:0]     min_valid_reg;
    logic [STAMP_W-1:0]   min_stamp_reg;
    logic                 out_valid_reg;
    logic                 found_reg;
    logic [VIDX_W-1:0]    vidx_reg;
    logic [PAGE_W-1:0]    vvp_reg;

    logic                 accept;
    logic                 idx_ok;
    logic                 rsp_load;
    logic [CNT_W-1:0]     limit;
    logic [COUNT_BITS-1:0] valid_cnt;
    logic                 match;
    logic                 g_elig;
    logic                 g_zero;
    logic                 g_take;
    logic                 e_take;
    logic                 take;
    logic                 early;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign idx_ok    = 32'(req.block_index) < BLOCK_DEPTH;
    assign limit     = (32'(cfg.blocks_in_use) < BLOCK_DEPTH) ?
                       CNT_W'(cfg.blocks_in_use) : CNT_W'(BLOCK_DEPTH);

    // The response register loads on a write item or at the end of a select.
    assign rsp_load  = (state_reg == S_FINISH) || (accept && (req.func == FUNC_WRITE));

    // Record port: a write item stores counts and stamp in one transfer.
    assign d_we       = accept && (req.func == FUNC_WRITE) && idx_ok;
    assign d_waddr    = ADDR_W'(req.block_index);
    assign d_wtotal   = COUNT_BITS'(req.total_pages);
    assign d_winvalid = COUNT_BITS'(req.invalid_pages);
    assign d_wstamp   = req.expiry_stamp;

    // The state memory is written by the clearing pass, by write items and
    // by the winner's list move; these never fall in the same cycle.
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = d_waddr;
        st_wdata = req.list_state;
        priority if (state_reg == S_CLEAR)
        begin
            st_we    = 1'b1;
            st_waddr = clr_reg;
            st_wdata = LS_EMPTY;
        end
        else if (state_reg == S_FINISH)
        begin
            st_we    = have_reg;
            st_waddr = best_reg;
            st_wdata = side_reg ? LS_GC_IN_USE : LS_GC_WRITE;
        end
        else
        begin
            st_we = d_we;
        end
    end

    assign rd_en   = (state_reg == S_SCAN) && (iss_reg < limit_reg);
    assign rd_addr = iss_reg[ADDR_W-1:0];

    // Evaluation of the record read in the previous cycle.
    assign valid_cnt = (rd_invalid > rd_total) ? '0 : (rd_total - rd_invalid);
    assign match     = rd_state == (side_reg ? LS_FULL : LS_GC_READ);
    assign g_elig    = match && (valid_cnt != rd_total);
    assign g_zero    = g_elig && (valid_cnt == '0);
    assign g_take    = g_elig && (g_zero || (CMP_W'(valid_cnt) < min_valid_reg));
    assign e_take    = match && (!have_reg || (rd_stamp < min_stamp_reg) ||
                       ((rd_stamp == min_stamp_reg) && (valid_cnt < best_valid_reg)));
    assign take      = pend_reg && (edt_reg ? e_take : g_take);
    assign early     = pend_reg && !edt_reg && g_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            iss_reg        <= '0;
            limit_reg      <= '0;
            pend_reg       <= 1'b0;
            ev_idx_reg     <= '0;
            side_reg       <= 1'b0;
            edt_reg        <= MODE_GREEDY;
            have_reg       <= 1'b0;
            best_reg       <= '0;
            best_valid_reg <= '0;
            min_valid_reg  <= '0;
            min_stamp_reg  <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            vidx_reg       <= '0;
            vvp_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= rsp_load || (out_valid_reg && !rsp.ready);

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(BLOCK_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.func == FUNC_WRITE)
                        begin
                            found_reg     <= 1'b0;
                            vidx_reg      <= '0;
                            vvp_reg       <= '0;
                        end
                        else
                        begin
                            side_reg       <= req.from_read_list;
                            edt_reg        <= cfg.selection_mode;
                            have_reg       <= 1'b0;
                            best_reg       <= '0;
                            best_valid_reg <= '0;
                            min_valid_reg  <= CMP_W'(cfg.valid_ceiling);
                            min_stamp_reg  <= '0;
                            iss_reg        <= '0;
                            pend_reg       <= 1'b0;
                            limit_reg      <= limit;
                            // The EDT write side never finds a victim.
                            if ((limit == '0) ||
                                ((cfg.selection_mode == MODE_EDT) && !req.from_read_list))
                            begin
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                    end
                end

                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    pend_reg   <= rd_en;
                    ev_idx_reg <= rd_addr;
                    if (take)
                    begin
                        have_reg       <= 1'b1;
                        best_reg       <= ev_idx_reg;
                        best_valid_reg <= valid_cnt;
                        min_valid_reg  <= CMP_W'(valid_cnt);
                        min_stamp_reg  <= rd_stamp;
                    end
                    if (pend_reg && ((iss_reg == limit_reg) || early))
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    found_reg     <= have_reg;
                    vidx_reg      <= have_reg ? VIDX_W'(best_reg) : cfg.blocks_in_use;
                    vvp_reg       <= have_reg ? PAGE_W'(best_valid_reg) : '0;
                    state_reg     <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.found              = found_reg;
    assign rsp.victim_index       = vidx_reg;
    assign rsp.victim_valid_pages = vvp_reg;

endmodule

// ===== rtl/core/gc_victim_block_selector.sv =====
// Top level of the garbage-collection victim block selector.
//
//  Channel   Direction  Moves
//  req       in         write one block record, or select a victim
//  rsp       out        found flag, victim index and its valid page count
//  APB       in/out     selection mode, valid ceiling, blocks in use
//
// A select item reads one record per cycle from the record memories, up to
// min(blocks_in_use, BLOCK_DEPTH) records; greedy mode ends the scan early
// when it hits a block with no valid pages, and no records are read when
// blocks_in_use is zero or EDT mode selects on the write side.
// After reset a clearing pass empties all BLOCK_DEPTH entries of the list state
// memory with req not ready; a req transfer needs a free or draining response.
module gc_victim_block_selector #(
    parameter int BLOCK_DEPTH = gvbs_pkg::DEF_BLOCK_DEPTH,
    parameter int COUNT_BITS  = gvbs_pkg::DEF_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    gvbs_req_if.sink                      req,
    gvbs_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gvbs_pkg::PADDR_W-1:0]  paddr,
    input  logic [gvbs_pkg::PDATA_W-1:0]  pwdata,
    output logic [gvbs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import gvbs_pkg::*;

    localparam int ADDR_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;

    cfg_t                  cfg;
    logic                  st_we;
    logic [ADDR_W-1:0]     st_waddr;
    logic [LS_W-1:0]       st_wdata;
    logic                  d_we;
    logic [ADDR_W-1:0]     d_waddr;
    logic [COUNT_BITS-1:0] d_wtotal;
    logic [COUNT_BITS-1:0] d_winvalid;
    logic [STAMP_W-1:0]    d_wstamp;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [LS_W-1:0]       rd_state;
    logic [COUNT_BITS-1:0] rd_total;
    logic [COUNT_BITS-1:0] rd_invalid;
    logic [STAMP_W-1:0]    rd_stamp;

    gvbs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gvbs_rec_mem #(
        .BLOCK_DEPTH (BLOCK_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_rec_mem (
        .clk        (clk),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .d_we       (d_we),
        .d_waddr    (d_waddr),
        .d_wtotal   (d_wtotal),
        .d_winvalid (d_winvalid),
        .d_wstamp   (d_wstamp),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_state   (rd_state),
        .rd_total   (rd_total),
        .rd_invalid (rd_invalid),
        .rd_stamp   (rd_stamp)
    );

    gvbs_scan #(
        .BLOCK_DEPTH (BLOCK_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .rsp        (rsp),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .d_we       (d_we),
        .d_waddr    (d_waddr),
        .d_wtotal   (d_wtotal),
        .d_winvalid (d_winvalid),
        .d_wstamp   (d_wstamp),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_state   (rd_state),
        .rd_total   (rd_total),
        .rd_invalid (rd_invalid),
        .rd_stamp   (rd_stamp)
    );

endmodule
